@@ src/tsc_pkg.sv @@
// Shared types, constants and helpers for the threshold spike snippet capture block.
// Used by threshold_spike_snippet_capture and the bench files; depends on nothing else.

package tsc_pkg;

    localparam int SAMPLE_W              = 16;
    localparam int PRE_W                 = 8;
    localparam int COUNT_W               = 10;
    localparam int CFG_INDEX_W           = 1;
    localparam int CFG_DATA_W            = 16;
    localparam int HISTORY_DEPTH_DEFAULT = 512;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [PRE_W-1:0]           pre_t;
    typedef logic [COUNT_W-1:0]         count_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_PRE_COUNT = 1'b1
    } cfg_index_t;

    localparam sample_t THRESHOLD_RESET = '0;
    localparam pre_t    PRE_COUNT_RESET = 8'd30;

    // Pre-crossing length as used: zero counts as one, and it never exceeds lim.
    function automatic pre_t eff_pre(input pre_t pre, input pre_t lim);
        pre_t p;
        p = (pre == '0) ? pre_t'(1) : pre;
        if (p > lim) begin
            p = lim;
        end
        return p;
    endfunction

endpackage

@@ src/tsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; no package dependency.

module tsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/threshold_spike_snippet_capture.sv @@
// Top level of the threshold spike snippet capture block.
// Depends on tsc_pkg and on tsc_ram for the two copies of the sample delay line.

// The block takes one signed 16-bit sample per request and sustains one request per
// clock cycle while the result side keeps up; the result of a request passes first
// through the registered delay-memory read and then, after the decision, through the
// output register. The rate is set by the delay memories: each copy has one write
// port for the new sample and one read port, one copy serving the detection tap that
// is 2P samples old and the other the snippet tap that is 3P samples old. The delay
// line reads as zeros after reset without any clearing pass: a fill count marks which
// ages have really been written, so the block accepts requests from the first cycle
// after reset. A detection is the first tested sample strictly above a non-negative
// threshold, or strictly below a negative one, after a tested sample that was not.
// The snippet of 3P samples (P before the crossing sample, the crossing sample, and
// 2P-1 after it) then streams out with tuser high on its first request and tlast on
// its last; no sample is tested during the following 3P requests. P is pre_count,
// where zero counts as one and values above (HISTORY_DEPTH-1)/3 are clipped to it.
// Configuration must only be written while the block is idle.

module threshold_spike_snippet_capture #(
    parameter int HISTORY_DEPTH = tsc_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream. s_tdata: [15:0] sample.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     s_tdata,
    // Result stream. m_tdata: [15:0] snippet_sample. m_tuser: [0] first_of_snippet.
    // m_tlast carries last_of_snippet.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tsc_pkg::SAMPLE_W-1:0]     m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast,
    // Configuration write port: index 0 is threshold, index 1 is pre_count.
    input  logic                             cfg_wr_en,
    input  logic [tsc_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    import tsc_pkg::*;

    localparam int AW          = $clog2(HISTORY_DEPTH);
    localparam int PRE_LIM_INT = (HISTORY_DEPTH - 1) / 3;
    localparam pre_t PRE_LIM   = (PRE_LIM_INT > 255) ? pre_t'(255) : pre_t'(PRE_LIM_INT);
    localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

    // Configuration. The effective P and the two tap ages are kept precomputed.
    sample_t threshold_reg;
    pre_t    pre_eff_reg;
    pre_t    pre_eff_next;
    count_t  win_reg;     // 3P, age of the snippet tap
    count_t  two_p_reg;   // 2P, age of the detection tap
    count_t  win_next;

    assign pre_eff_next = eff_pre(pre_t'(cfg_wr_data), PRE_LIM);
    assign win_next     = count_t'({pre_eff_next, 1'b0}) + count_t'(pre_eff_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            pre_eff_reg   <= eff_pre(PRE_COUNT_RESET, PRE_LIM);
            win_reg       <= count_t'({eff_pre(PRE_COUNT_RESET, PRE_LIM), 1'b0})
                             + count_t'(eff_pre(PRE_COUNT_RESET, PRE_LIM));
            two_p_reg     <= count_t'({eff_pre(PRE_COUNT_RESET, PRE_LIM), 1'b0});
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_THRESHOLD: begin
                    threshold_reg <= sample_t'(cfg_wr_data);
                end
                CFG_PRE_COUNT: begin
                    pre_eff_reg <= pre_eff_next;
                    win_reg     <= win_next;
                    two_p_reg   <= count_t'({pre_eff_next, 1'b0});
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake and pipeline control.
    logic s_accept;
    logic s2_valid_reg;
    logic out_free;
    logic s2_advance;
    logic m_valid_reg;

    assign out_free   = !m_valid_reg || m_tready;
    assign s2_advance = s2_valid_reg && out_free;
    assign s_tready   = !s2_valid_reg || out_free;
    assign s_accept   = s_tvalid && s_tready;

    // Stage 1: write the new sample and address both taps relative to the new pointer.
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [AW-1:0] fill_reg;     // samples written since reset, saturating
    logic [AW:0]   age_a;
    logic [AW:0]   age_b;
    logic [AW:0]   diff_a;
    logic [AW:0]   diff_b;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          hit_a;
    logic          hit_b;

    assign wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign age_a   = (AW+1)'(two_p_reg);
    assign age_b   = (AW+1)'(win_reg);
    assign diff_a  = {1'b0, wp_next} - age_a;
    assign diff_b  = {1'b0, wp_next} - age_b;
    // A negative difference wraps around the ring.
    assign rd_addr_a = diff_a[AW] ? AW'(diff_a + DEPTH_EXT) : diff_a[AW-1:0];
    assign rd_addr_b = diff_b[AW] ? AW'(diff_b + DEPTH_EXT) : diff_b[AW-1:0];
    // An age reaches a real sample only once that many samples came before this one;
    // anything older is still the reset content, which is zero.
    assign hit_a = {1'b0, fill_reg} >= age_a;
    assign hit_b = {1'b0, fill_reg} >= age_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (s_accept) begin
            wp_reg <= wp_next;
            if (fill_reg != PTR_LAST) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    logic [SAMPLE_W-1:0] rd_data_a;
    logic [SAMPLE_W-1:0] rd_data_b;
    logic                hit_a_reg;
    logic                hit_b_reg;

    tsc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram_detect (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (wp_next),
        .wr_data (s_tdata),
        .rd_en   (s_accept),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    tsc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram_snippet (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (wp_next),
        .wr_data (s_tdata),
        .rd_en   (s_accept),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_advance) begin
            s2_valid_reg <= 1'b0;
        end
    end

    // The hit flags travel with the read data and hold with it under a stall.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hit_a_reg <= hit_a;
            hit_b_reg <= hit_b;
        end
    end

    // Stage 2: detection, snippet streaming and the refractory gap.
    sample_t tap_a;
    sample_t tap_b;
    logic    beyond;
    logic    was_beyond_reg;
    logic    was_beyond_next;
    count_t  refr_reg;
    count_t  refr_next;
    count_t  emit_reg;
    count_t  emit_next;
    logic    emit_out;
    logic    first_out;
    logic    last_out;

    assign tap_a  = hit_a_reg ? sample_t'(rd_data_a) : '0;
    assign tap_b  = hit_b_reg ? sample_t'(rd_data_b) : '0;
    assign beyond = threshold_reg[SAMPLE_W-1] ? (tap_a < threshold_reg)
                                              : (tap_a > threshold_reg);

    always_comb begin
        was_beyond_next = was_beyond_reg;
        refr_next       = refr_reg;
        emit_next       = emit_reg;
        emit_out        = 1'b0;
        first_out       = 1'b0;
        last_out        = 1'b0;
        if (s2_advance) begin
            if (emit_reg != '0) begin
                emit_out  = 1'b1;
                last_out  = (emit_reg == count_t'(1));
                emit_next = emit_reg - 1'b1;
                if (refr_reg != '0) begin
                    refr_next = refr_reg - 1'b1;
                end
            end else if (refr_reg != '0) begin
                refr_next = refr_reg - 1'b1;
            end else begin
                was_beyond_next = beyond;
                if (beyond && !was_beyond_reg) begin
                    emit_out  = 1'b1;
                    first_out = 1'b1;
                    emit_next = win_reg - 1'b1;
                    refr_next = win_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_beyond_reg <= 1'b0;
            refr_reg       <= '0;
            emit_reg       <= '0;
        end else begin
            was_beyond_reg <= was_beyond_next;
            refr_reg       <= refr_next;
            emit_reg       <= emit_next;
        end
    end

    // Output register.
    sample_t m_data_reg;
    logic    m_first_reg;
    logic    m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_out) begin
            m_data_reg  <= tap_b;
            m_first_reg <= first_out;
            m_last_reg  <= last_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_first_reg;
    assign m_tlast  = m_last_reg;

    // While a snippet streams, the refractory count stays exactly one ahead of it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reg != '0 |-> refr_reg == emit_reg + 1'b1)
        else $error("refractory count out of step with snippet position");

    // A stalled decision stage must keep its memory read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !out_free |=> $stable(rd_data_a) && $stable(rd_data_b))
        else $error("delay memory read data changed under a stall");

    // A snippet is never shorter than three samples, so no result is both first and last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tlast))
        else $error("result marked both first and last of a snippet");

    // The effective pre-crossing length stays inside the range the delay line can hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pre_eff_reg != '0 && pre_eff_reg <= PRE_LIM)
        else $error("effective pre-crossing length out of range");

endmodule

@@ bench/snippet_checker.sv @@
// Checker for the threshold spike snippet capture block: predicts each snippet result.
// Watches the sample, result and configuration ports; depends on tsc_pkg only.

module snippet_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tsc_pkg::SAMPLE_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tsc_pkg::SAMPLE_W-1:0]    m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [tsc_pkg::CFG_INDEX_W-1:0] cfg_addr,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output int                              mismatches,
    output int                              beats_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam int DEPTH   = HISTORY_DEPTH_DEFAULT;
    localparam int PRE_MAX = (DEPTH - 1) / 3;

    typedef struct {
        sample_t data;
        logic    first;
        logic    last;
    } snip_beat_t;

    snip_beat_t snippet_q[$];

    sample_t delay_line [DEPTH];
    int      newest_ptr;
    logic    over_level;
    int      quiet_left;
    int      snippet_left;
    sample_t level;
    pre_t    pre_setting;

    function automatic int pre_in_use();
        int p;
        p = pre_setting;
        if (p < 1) p = 1;
        if (p > PRE_MAX) p = PRE_MAX;
        return p;
    endfunction

    function automatic sample_t tap(input int age);
        return delay_line[(newest_ptr + DEPTH - (age % DEPTH)) % DEPTH];
    endfunction

    function automatic snip_beat_t make_beat(input sample_t d, input logic f, input logic l);
        snip_beat_t b;
        b.data  = d;
        b.first = f;
        b.last  = l;
        return b;
    endfunction

    // One accepted sample: store it, then either stream, sit out the gap, or test.
    task automatic advance_sample(input sample_t s);
        int      p;
        int      win;
        sample_t tested;
        logic    beyond;
        p   = pre_in_use();
        win = 3 * p;
        newest_ptr = (newest_ptr + 1) % DEPTH;
        delay_line[newest_ptr] = s;
        if (snippet_left > 0) begin
            snippet_q.push_back(make_beat(tap(win), 1'b0, snippet_left == 1));
            snippet_left--;
            if (quiet_left > 0) quiet_left--;
        end else if (quiet_left > 0) begin
            quiet_left--;
        end else begin
            tested = tap(2 * p);
            beyond = (level >= 0) ? (tested > level) : (tested < level);
            if (beyond && !over_level) begin
                snippet_q.push_back(make_beat(tap(win), 1'b1, 1'b0));
                snippet_left = win - 1;
                quiet_left   = win;
            end
            over_level = beyond;
        end
    endtask

    task automatic compare_beat();
        snip_beat_t want;
        if (snippet_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result request: data %0d first %0b last %0b",
                         $signed(m_tdata), m_tuser, m_tlast);
            end
        end else begin
            want = snippet_q.pop_front();
            if (m_tdata !== want.data || m_tuser !== want.first || m_tlast !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected data %0d first %0b last %0b, ",
                             want.data, want.first, want.last,
                             "got data %0d first %0b last %0b",
                             $signed(m_tdata), m_tuser, m_tlast);
                end
            end
        end
    endtask

    initial begin
        mismatches    = 0;
        beats_waiting = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) delay_line[i] = '0;
            newest_ptr   = 0;
            over_level   = 1'b0;
            quiet_left   = 0;
            snippet_left = 0;
            level        = THRESHOLD_RESET;
            pre_setting  = PRE_COUNT_RESET;
            snippet_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_THRESHOLD) level = sample_t'(cfg_wr_data);
                else if (cfg_addr == CFG_PRE_COUNT) pre_setting = cfg_wr_data[PRE_W-1:0];
            end
            if (s_tvalid && s_tready) advance_sample(sample_t'(s_tdata));
            if (m_tvalid && m_tready) compare_beat();
        end
        beats_waiting = snippet_q.size();
    end

endmodule

@@ bench/threshold_spike_snippet_capture_tb.sv @@
// Testbench top for the threshold spike snippet capture block.
// Drives samples and configuration, instantiates the block and snippet_checker.

module threshold_spike_snippet_capture_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsc_pkg::*;

    // Far above the slowest correct run, even with both sides idling heavily.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SEG_ITEMS    = 44;
    localparam int SEGS_PER_RUN = 6;

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    int mismatches;
    int beats_waiting;
    int cycle_count    = 0;
    int sender_idle    = 0;   // percent of cycles the sample source holds back
    int receiver_stall = 0;   // percent of cycles the result sink refuses a request
    int cur_thr        = 0;   // threshold currently loaded, steers the sample shaping

    threshold_spike_snippet_capture dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [15:0] sample
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [15:0] snippet_sample
        .m_tuser     (m_tuser),      // [0] first_of_snippet
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    snippet_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .beats_waiting (beats_waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The result sink decides anew every cycle whether it takes a request.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Samples are mostly placed around the current threshold so that crossings and runs
    // beyond the level come up often; the rest is full-range noise so that every bit of the
    // sample toggles.
    function automatic logic [15:0] pick_sample(input int thr);
        int v;
        int r;
        r = $urandom_range(99);
        if (r < 20) return 16'($urandom);
        if (r < 35) begin
            v = (thr >= 0) ? thr + 1 + $urandom_range(3000) : thr - 1 - $urandom_range(3000);
        end else begin
            v = (thr >= 0) ? thr - $urandom_range(3000) : thr + $urandom_range(3000);
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Offers one sample request and returns at the edge where it was accepted. With no
    // gap drawn, tvalid stays high straight from the previous request.
    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle && gap < 200) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops the sample stream and waits until every predicted result has come back, then
    // waits on so that a request still inside the pipeline has settled.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_waiting != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // A write lasts one cycle, and the task returns with the enable low again.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [15:0] early_pos [14];
        logic [15:0] early_neg [10];
        int          send_pct  [4];
        int          stall_pct [4];
        int          pre_edge  [4];
        int          thr_edge  [4];
        int          pre;
        int          r;
        logic [15:0] thr_bits;

        early_pos = '{16'h7FFF, 16'h8000, 16'd101, 16'd100, 16'h0000, 16'hFFFF, 16'h5555,
                      16'hAAAA, 16'd200, 16'd50, 16'd101, 16'd99, 16'd150, 16'h0000};
        early_neg = '{16'hFFFE, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFD, 16'hFFFD,
                      16'h0001, 16'hFFFE, 16'h7FFF, 16'hFFFF};
        send_pct  = '{0, 84, 0, 22};
        stall_pct = '{0, 0, 84, 22};
        pre_edge  = '{1, 170, 255, 1};
        thr_edge  = '{32767, -32768, 0, -1};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short window and a positive level right after reset: the first snippet reaches
        // back into the never-written part of the delay line, which must read as zeros.
        // Sample extremes, the level itself and one above it are all offered.
        write_reg(CFG_PRE_COUNT, 16'h0004);
        write_reg(CFG_THRESHOLD, 16'd100);
        cur_thr = 100;
        foreach (early_pos[i]) send_sample(early_pos[i]);
        drain_stream();

        // A pre count of zero behaves as one; the upper data bits must be ignored. A
        // negative level flips the test to samples strictly below it.
        write_reg(CFG_PRE_COUNT, 16'hFF00);
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        cur_thr = -1;
        foreach (early_neg[i]) send_sample(early_neg[i]);
        drain_stream();

        // Random part: four idling phases, each split into segments with fresh settings.
        // Segments drain only the predicted results, so a new pre count can land in the
        // middle of a snippet or a refractory gap.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle    = send_pct[ph];
            receiver_stall = stall_pct[ph];
            for (int seg = 0; seg < SEGS_PER_RUN; seg++) begin
                r = $urandom_range(99);
                if (seg == 0) pre = pre_edge[ph];
                else if (r < 65) pre = $urandom_range(6, 1);
                else if (r < 75) pre = 0;
                else if (r < 85) pre = $urandom_range(40, 7);
                else if (r < 92) pre = 170;
                else pre = $urandom_range(255, 171);

                if (seg == 1) begin
                    cur_thr = thr_edge[ph];
                end else if ($urandom_range(1) == 0) begin
                    thr_bits = 16'($urandom);
                    cur_thr  = $signed(thr_bits);
                end else begin
                    cur_thr = int'($urandom_range(400)) - 200;
                end

                write_reg(CFG_THRESHOLD, cur_thr[15:0]);
                write_reg(CFG_PRE_COUNT, {8'($urandom), pre[7:0]});
                for (int n = 0; n < SEG_ITEMS; n++) send_sample(pick_sample(cur_thr));
                drain_stream();
            end
        end

        // Any stray result after the last expected one is caught here.
        receiver_stall = 0;
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && beats_waiting == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
